### design/sab_pkg.sv
`default_nettype none

package sab_pkg;

    // Default geometry, handed to the top-level parameters.
    localparam int SCREEN_W_DEF   = 256;
    localparam int SCREEN_H_DEF   = 256;
    localparam int SPRITE_MAX_DEF = 256;

    // Width of the signed coordinate arithmetic (col + pos - anchor).
    localparam int COORD_W = 18;

    // Width of the screen coordinates on the result channel.
    localparam int PIX_COORD_W = 8;

    // Width of the configuration port address.
    localparam int CFG_AW = 5;

    // Blend constants: full weight is 255 * 256, unit opacity is 256 in Q8.
    localparam logic [15:0] FULL_WEIGHT = 16'd65280;
    localparam logic [8:0]  GALPHA_ONE  = 9'd256;
    localparam logic [7:0]  ALPHA_MAX   = 8'hFF;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_POS_X    = 3'd0,
        REG_POS_Y    = 3'd1,
        REG_ANCHOR_X = 3'd2,
        REG_ANCHOR_Y = 3'd3,
        REG_GALPHA   = 3'd4
    } cfg_reg_t;

    // Configuration values as seen by the datapath.
    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] anchor_x;
        logic [15:0] anchor_y;
        logic [8:0]  galpha;
    } cfg_t;

    // Truncating division of a blend numerator by 65280.
    // The low byte is dropped first (divide by 256), then the quotient by
    // 255 is formed as (n + 1 + n/256) / 256, which is exact for n <= 65025.
    function automatic logic [7:0] div_full_weight(input logic [23:0] num);
        logic [15:0] n;
        logic [16:0] sum;
        n   = num[23:8];
        sum = 17'(n) + 17'd1 + 17'(n[15:8]);
        return sum[15:8];
    endfunction

endpackage

`default_nettype wire

### design/sab_cfg.sv
`default_nettype none

module sab_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sab_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output sab_pkg::cfg_t                   cfg
);

    logic [15:0]       pos_x_reg;
    logic [15:0]       pos_y_reg;
    logic [15:0]       anchor_x_reg;
    logic [15:0]       anchor_y_reg;
    logic [8:0]        galpha_reg;
    logic              wr_en;
    sab_pkg::cfg_reg_t reg_idx;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = sab_pkg::cfg_reg_t'(paddr[sab_pkg::CFG_AW-1:2]);

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            galpha_reg   <= sab_pkg::GALPHA_ONE;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                sab_pkg::REG_POS_X:    pos_x_reg    <= pwdata[15:0];
                sab_pkg::REG_POS_Y:    pos_y_reg    <= pwdata[15:0];
                sab_pkg::REG_ANCHOR_X: anchor_x_reg <= pwdata[15:0];
                sab_pkg::REG_ANCHOR_Y: anchor_y_reg <= pwdata[15:0];
                sab_pkg::REG_GALPHA:   galpha_reg   <= pwdata[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read-back of the stored values.
    always_comb
    begin
        unique case (reg_idx)
            sab_pkg::REG_POS_X:    prdata = {16'b0, pos_x_reg};
            sab_pkg::REG_POS_Y:    prdata = {16'b0, pos_y_reg};
            sab_pkg::REG_ANCHOR_X: prdata = {16'b0, anchor_x_reg};
            sab_pkg::REG_ANCHOR_Y: prdata = {16'b0, anchor_y_reg};
            sab_pkg::REG_GALPHA:   prdata = {23'b0, galpha_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.pos_x    = pos_x_reg;
    assign cfg.pos_y    = pos_y_reg;
    assign cfg.anchor_x = anchor_x_reg;
    assign cfg.anchor_y = anchor_y_reg;
    assign cfg.galpha   = galpha_reg;

endmodule

`default_nettype wire

### design/sab_fb_ram.sv
`default_nettype none

module sab_fb_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/sab_blend.sv
`default_nettype none

module sab_blend (
    input  wire logic        clk,
    input  wire logic        load,
    input  wire logic [31:0] src_pixel,
    input  wire logic [31:0] dst_pixel,
    input  wire logic [15:0] weight,
    output logic      [31:0] pixel
);

    logic [15:0] inv_weight;
    logic [23:0] num_next [3];
    logic [23:0] num_reg  [3];
    logic [8:0]  alpha_sum;
    logic [7:0]  alpha_next;
    logic [7:0]  alpha_reg;

    assign inv_weight = sab_pkg::FULL_WEIGHT - weight;

    // One lane per color channel: weighted sum of source and destination.
    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        assign num_next[c] = 24'(src_pixel[8*c +: 8]) * 24'(weight)
                           + 24'(dst_pixel[8*c +: 8]) * 24'(inv_weight);
    end

    // Alpha channel saturates to the sum of both alphas.
    assign alpha_sum  = 9'(src_pixel[31:24]) + 9'(dst_pixel[31:24]);
    assign alpha_next = alpha_sum[8] ? sab_pkg::ALPHA_MAX : alpha_sum[7:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg   <= num_next;
            alpha_reg <= alpha_next;
        end
    end

    // Division by the full weight happens after the register.
    assign pixel = {alpha_reg,
                    sab_pkg::div_full_weight(num_reg[2]),
                    sab_pkg::div_full_weight(num_reg[1]),
                    sab_pkg::div_full_weight(num_reg[0])};

endmodule

`default_nettype wire

### design/sprite_alpha_blit.sv
// Alpha-blending sprite blitter over an on-chip framebuffer.
// Input channel (in_valid, in_stall): one sprite pixel per transfer with its
// column and row in the sprite. Result channel (out_valid, out_stall): one
// result per input transfer, in order, telling whether and where the pixel
// was written and the blended ARGB value stored.
// Configuration goes through the APB port (position, anchor, global alpha).
// Pipeline: accept and framebuffer read, multiply stage, divide and write
// back into the output register. Throughput is one pixel per cycle while
// out_stall is low and consecutive pixels go to different framebuffer
// words; a pixel that hits the same word as one of the two pixels still
// ahead of it is held off by in_stall until that write is done. The
// framebuffer has a single read port and a single write port.
// After reset the framebuffer is cleared one word a cycle, over all
// SCREEN_W * SCREEN_H words (65536 by default); in_stall stays high during
// that pass, while configuration writes are taken as usual.
// When out_stall is high the result holds in the output register; the
// stages behind it keep filling until the pipeline is full, then in_stall
// rises.
`default_nettype none

module sprite_alpha_blit #(
    parameter int SCREEN_W   = sab_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H   = sab_pkg::SCREEN_H_DEF,
    parameter int SPRITE_MAX = sab_pkg::SPRITE_MAX_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Configuration port.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sab_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    // Input channel.
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [7:0]                 col,
    input  wire logic [7:0]                 row,
    input  wire logic [31:0]                src_pixel,
    // Result channel.
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            written,
    output logic [sab_pkg::PIX_COORD_W-1:0] screen_x,
    output logic [sab_pkg::PIX_COORD_W-1:0] screen_y,
    output logic [31:0]                     out_pixel
);

    localparam int DEPTH = SCREEN_W * SCREEN_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(SCREEN_W);
    localparam int YW    = $clog2(SCREEN_H);
    localparam int CW    = sab_pkg::COORD_W;
    localparam int PW    = sab_pkg::PIX_COORD_W;

    sab_pkg::cfg_t cfg;

    logic [CW-1:0] x_full;
    logic [CW-1:0] y_full;
    logic          col_ok;
    logic          row_ok;
    logic          on_x;
    logic          on_y;
    logic          in_hit;
    logic [AW-1:0] in_addr;
    logic [8:0]    g_sat;
    logic [16:0]   w_full;
    logic          hazard;
    logic          in_accept;

    logic          adv_out;
    logic          adv2;
    logic          adv1;

    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic          valid1_reg;
    logic          hit1_reg;
    logic [AW-1:0] addr1_reg;
    logic [PW-1:0] sx1_reg;
    logic [PW-1:0] sy1_reg;
    logic [31:0]   src1_reg;
    logic [15:0]   w1_reg;
    logic [31:0]   dst1;

    logic          valid2_reg;
    logic          hit2_reg;
    logic [AW-1:0] addr2_reg;
    logic [PW-1:0] sx2_reg;
    logic [PW-1:0] sy2_reg;
    logic [31:0]   blend_pixel;

    logic          out_valid_reg;
    logic          written_reg;
    logic [PW-1:0] screen_x_reg;
    logic [PW-1:0] screen_y_reg;
    logic [31:0]   out_pixel_reg;

    logic          fb_we;
    logic [AW-1:0] fb_waddr;
    logic [31:0]   fb_wdata;
    logic          wb_en;

    sab_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Screen position of the incoming pixel, in wrapping signed arithmetic.
    assign x_full = CW'(col) + {{(CW-16){cfg.pos_x[15]}}, cfg.pos_x}
                  - {{(CW-16){cfg.anchor_x[15]}}, cfg.anchor_x};
    assign y_full = CW'(row) + {{(CW-16){cfg.pos_y[15]}}, cfg.pos_y}
                  - {{(CW-16){cfg.anchor_y[15]}}, cfg.anchor_y};

    // Clip against the sprite bounds and the screen.
    assign col_ok = CW'(col) < CW'(SPRITE_MAX);
    assign row_ok = CW'(row) < CW'(SPRITE_MAX);
    assign on_x   = !x_full[CW-1] && (x_full < CW'(SCREEN_W));
    assign on_y   = !y_full[CW-1] && (y_full < CW'(SCREEN_H));
    assign in_hit = col_ok && row_ok && on_x && on_y;

    // Row-major framebuffer address.
    assign in_addr = AW'(y_full[YW-1:0]) * AW'(SCREEN_W) + AW'(x_full[XW-1:0]);

    // Blend weight: saturated global alpha times source alpha.
    assign g_sat  = (cfg.galpha > sab_pkg::GALPHA_ONE) ? sab_pkg::GALPHA_ONE : cfg.galpha;
    assign w_full = 17'(g_sat) * 17'(src_pixel[31:24]);

    // Interlock against words still waiting for their write-back.
    assign hazard = in_hit
                  && ((valid1_reg && hit1_reg && (addr1_reg == in_addr))
                   || (valid2_reg && hit2_reg && (addr2_reg == in_addr)));

    // Stage advance: each stage moves when the next one is free or moving.
    assign adv_out   = !out_valid_reg || !out_stall;
    assign adv2      = !valid2_reg || adv_out;
    assign adv1      = !valid1_reg || adv2;
    assign in_stall  = clearing_reg || !adv1 || hazard;
    assign in_accept = in_valid && !in_stall;
    assign wb_en     = adv_out && valid2_reg && hit2_reg;

    // Clearing pass over the framebuffer after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Framebuffer write: zeros while clearing, blended pixels afterwards.
    assign fb_we    = clearing_reg || wb_en;
    assign fb_waddr = clearing_reg ? clr_cnt_reg : addr2_reg;
    assign fb_wdata = clearing_reg ? 32'b0 : blend_pixel;

    sab_fb_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_fb_ram (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .re    (in_accept && in_hit),
        .raddr (in_addr),
        .rdata (dst1)
    );

    // Stage 1: accepted item, framebuffer word arrives from the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else if (adv1)
        begin
            valid1_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hit1_reg  <= in_hit;
            addr1_reg <= in_addr;
            sx1_reg   <= x_full[PW-1:0];
            sy1_reg   <= y_full[PW-1:0];
            src1_reg  <= src_pixel;
            w1_reg    <= w_full[15:0];
        end
    end

    // Stage 2: channel products registered inside the blend unit.
    sab_blend u_blend (
        .clk       (clk),
        .load      (adv2 && valid1_reg),
        .src_pixel (src1_reg),
        .dst_pixel (dst1),
        .weight    (w1_reg),
        .pixel     (blend_pixel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
        end
        else if (adv2)
        begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && valid1_reg)
        begin
            hit2_reg  <= hit1_reg;
            addr2_reg <= addr1_reg;
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
        end
    end

    // Output register; off-screen pixels report all zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && valid2_reg)
        begin
            written_reg   <= hit2_reg;
            screen_x_reg  <= hit2_reg ? sx2_reg : '0;
            screen_y_reg  <= hit2_reg ? sy2_reg : '0;
            out_pixel_reg <= hit2_reg ? blend_pixel : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign written   = written_reg;
    assign screen_x  = screen_x_reg;
    assign screen_y  = screen_y_reg;
    assign out_pixel = out_pixel_reg;

    // Two in-flight writes never target the same framebuffer word.
    a_no_same_word: assert property (@(posedge clk) disable iff (!rst_n)
        (valid1_reg && hit1_reg && valid2_reg && hit2_reg) |-> (addr1_reg != addr2_reg))
        else $error("two in-flight pixels target the same framebuffer word");

    // A dropped pixel reports zeros in every field.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !written_reg)
            |-> (out_pixel_reg == '0 && screen_x_reg == '0 && screen_y_reg == '0))
        else $error("dropped pixel reports nonzero fields");

    // The clearing pass ends only after the last word.
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clr_cnt_reg) == AW'(DEPTH - 1)))
        else $error("clearing pass ended early");

    // A pending write-back holds while the output side is stalled.
    a_wb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid2_reg && out_valid_reg && out_stall)
            |=> (valid2_reg && $stable(addr2_reg) && $stable(hit2_reg)))
        else $error("pending write-back lost under output stall");

endmodule

`default_nettype wire

### tb/sab_blend_checker.sv
`default_nettype none

module sab_blend_checker #(
    parameter int SCREEN_W   = 256,
    parameter int SCREEN_H   = 256,
    parameter int SPRITE_MAX = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port, watched for register writes.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    // Input channel.
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  col,
    input  wire logic [7:0]  row,
    input  wire logic [31:0] src_pixel,
    // Result channel.
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        written,
    input  wire logic [7:0]  screen_x,
    input  wire logic [7:0]  screen_y,
    input  wire logic [31:0] out_pixel,
    output int               errors,
    output int               pending
);

    localparam logic [63:0] BLEND_DIVISOR = 64'd65280;
    localparam logic [63:0] OPACITY_ONE   = 64'd256;
    localparam logic [7:0]  ALPHA_SAT     = 8'hFF;

    typedef struct packed {
        logic        written;
        logic [7:0]  sx;
        logic [7:0]  sy;
        logic [31:0] pixel;
    } blit_result_t;

    // Shadow copy of the configuration registers.
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] anch_x;
    logic signed [15:0] anch_y;
    logic [8:0]         opacity;

    // Shadow framebuffer and the results still owed by the block.
    logic [31:0]  frame_model [SCREEN_W*SCREEN_H];
    blit_result_t results_due [$];

    // Blends one ARGB pixel over another with truncation and alpha saturation.
    function automatic logic [31:0] blend_argb(input logic [31:0] src, input logic [31:0] dst,
                                               input logic [8:0] galpha);
        logic [63:0] g;
        logic [63:0] w;
        logic [63:0] s;
        logic [63:0] d;
        logic [63:0] num;
        logic [8:0]  asum;
        logic [31:0] res;
        int          sh;
        g = (64'(galpha) > OPACITY_ONE) ? OPACITY_ONE : 64'(galpha);
        w = g * 64'(src[31:24]);
        asum = 9'(src[31:24]) + 9'(dst[31:24]);
        res = '0;
        res[31:24] = (asum > 9'd255) ? ALPHA_SAT : asum[7:0];
        for (sh = 0; sh < 24; sh += 8)
        begin
            s = 64'(src[sh+:8]);
            d = 64'(dst[sh+:8]);
            num = s * w + d * (BLEND_DIVISOR - w);
            res[sh+:8] = 8'(num / BLEND_DIVISOR);
        end
        return res;
    endfunction

    // Places a sprite pixel on screen, updates the shadow framebuffer and
    // returns the result the block must report for it.
    function automatic blit_result_t place_and_blend(input logic [7:0] c, input logic [7:0] r,
                                                     input logic [31:0] src);
        blit_result_t res;
        int           x;
        int           y;
        int           addr;
        logic [31:0]  pix;
        res = '0;
        x = int'(c) + int'(origin_x) - int'(anch_x);
        y = int'(r) + int'(origin_y) - int'(anch_y);
        if (int'(c) < SPRITE_MAX && int'(r) < SPRITE_MAX &&
            x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H)
        begin
            addr = y * SCREEN_W + x;
            pix = blend_argb(src, frame_model[addr], opacity);
            frame_model[addr] = pix;
            res.written = 1'b1;
            res.sx = x[7:0];
            res.sy = y[7:0];
            res.pixel = pix;
        end
        return res;
    endfunction

    // Watch both channels and the configuration port on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        blit_result_t due;
        if (!rst_n)
        begin
            origin_x = '0;
            origin_y = '0;
            anch_x = '0;
            anch_y = '0;
            opacity = 9'd256;
            foreach (frame_model[i])
                frame_model[i] = '0;
            results_due.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            // Register writes; indexes past the last register are ignored.
            if (psel && penable && pwrite && pready)
            begin
                case (sab_pkg::cfg_reg_t'(paddr[4:2]))
                    sab_pkg::REG_POS_X:    origin_x = pwdata[15:0];
                    sab_pkg::REG_POS_Y:    origin_y = pwdata[15:0];
                    sab_pkg::REG_ANCHOR_X: anch_x = pwdata[15:0];
                    sab_pkg::REG_ANCHOR_Y: anch_y = pwdata[15:0];
                    sab_pkg::REG_GALPHA:   opacity = pwdata[8:0];
                    default:               ;
                endcase
            end

            // A result transfer is checked against the oldest expectation.
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result transfer with no pixel outstanding");
                    errors++;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (written !== due.written)
                    begin
                        $error("written: expected %0d, got %0d", due.written, written);
                        errors++;
                    end
                    if (screen_x !== due.sx)
                    begin
                        $error("screen_x: expected %0d, got %0d", due.sx, screen_x);
                        errors++;
                    end
                    if (screen_y !== due.sy)
                    begin
                        $error("screen_y: expected %0d, got %0d", due.sy, screen_y);
                        errors++;
                    end
                    if (out_pixel !== due.pixel)
                    begin
                        $error("out_pixel: expected %08h, got %08h", due.pixel, out_pixel);
                        errors++;
                    end
                end
            end

            // An input transfer adds one expected result at the tail.
            if (in_valid && !in_stall)
                results_due.insert(results_due.size(), place_and_blend(col, row, src_pixel));

            pending = results_due.size();
        end
    end

endmodule

`default_nettype wire

### tb/tb_sprite_alpha_blit.sv
`default_nettype none

module tb_sprite_alpha_blit;

    localparam int          WATCHDOG_LIMIT = 200000;
    localparam int          RAND_PHASES    = 8;
    localparam int          PHASE_PIXELS   = 250;
    localparam logic [2:0]  UNUSED_REG     = 3'd5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  col = '0;
    logic [7:0]  row = '0;
    logic [31:0] src_pixel = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        written;
    logic [7:0]  screen_x;
    logic [7:0]  screen_y;
    logic [31:0] out_pixel;

    int errors;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    sprite_alpha_blit #(
        .SCREEN_W   (256),
        .SCREEN_H   (256),
        .SPRITE_MAX (256)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .col       (col),
        .row       (row),
        .src_pixel (src_pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .written   (written),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .out_pixel (out_pixel)
    );

    sab_blend_checker #(
        .SCREEN_W   (256),
        .SCREEN_H   (256),
        .SPRITE_MAX (256)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .col       (col),
        .row       (row),
        .src_pixel (src_pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .written   (written),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .out_pixel (out_pixel),
        .errors    (errors),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    // The receiver stalls at random with the current percentage.
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Watchdog: ends the run after too many cycles without any transfer.
    // The limit covers the framebuffer clearing pass after reset.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sprite_alpha_blit test failed");
            $finish;
        end
    end

    // One register write through the APB port; bits above the register's
    // width carry random noise that the block must drop.
    task automatic set_reg(input logic [2:0] idx, input int value);
        logic [31:0] data;
        data = $urandom();
        if (idx == sab_pkg::REG_GALPHA)
            data[8:0] = value[8:0];
        else
            data[15:0] = value[15:0];
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_layout(input int px, input int py, input int ax, input int ay,
                              input int ga);
        set_reg(sab_pkg::REG_POS_X, px);
        set_reg(sab_pkg::REG_POS_Y, py);
        set_reg(sab_pkg::REG_ANCHOR_X, ax);
        set_reg(sab_pkg::REG_ANCHOR_Y, ay);
        set_reg(sab_pkg::REG_GALPHA, ga);
    endtask

    // Pause the sender until every pixel in flight has come back.
    task automatic drain_pipeline();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One sprite pixel transfer, preceded by a random idle gap.
    task automatic send_pixel(input logic [7:0] c, input logic [7:0] r, input logic [31:0] p);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        col = c;
        row = r;
        src_pixel = p;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Random ARGB with a bias toward fully opaque and fully clear alpha.
    function automatic logic [31:0] rand_argb();
        logic [31:0] p;
        p = $urandom();
        case ($urandom_range(0, 7))
            0, 1:    p[31:24] = 8'hFF;
            2:       p[31:24] = 8'h00;
            default: ;
        endcase
        return p;
    endfunction

    // Random layout: mostly placed so that most pixels land on screen.
    task automatic random_layout();
        int ax;
        int ay;
        int px;
        int py;
        int ga;
        ax = $urandom_range(0, 65535);
        ay = $urandom_range(0, 65535);
        case ($urandom_range(0, 7))
            0:
            begin
                px = $urandom_range(0, 65535);
                py = $urandom_range(0, 65535);
            end
            1:
            begin
                ax = $urandom_range(0, 1) ? 32767 : -32768;
                ay = $urandom_range(0, 1) ? 32767 : -32768;
                px = $urandom_range(0, 1) ? 32767 : -32768;
                py = $urandom_range(0, 1) ? 32767 : -32768;
            end
            default:
            begin
                px = ax + $urandom_range(0, 128) - 64;
                py = ay + $urandom_range(0, 128) - 64;
            end
        endcase
        case ($urandom_range(0, 5))
            0:       ga = 256;
            1:       ga = 0;
            2:       ga = $urandom_range(257, 511);
            default: ga = $urandom_range(0, 256);
        endcase
        set_layout(px, py, ax, ay, ga);
    endtask

    initial
    begin
        int         ph;
        int         n;
        logic [7:0] base_c;
        logic [7:0] base_r;
        logic [7:0] c;
        logic [7:0] r;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset layout, pixels land at their own column and row.
        // Repeated hits on one word exercise the read-modify-write hazard.
        send_pixel(8'd0, 8'd0, 32'hFFFFFFFF);
        send_pixel(8'd0, 8'd0, 32'h80123456);
        send_pixel(8'd0, 8'd0, 32'h00ABCDEF);
        send_pixel(8'd1, 8'd0, 32'h7F00FF00);
        send_pixel(8'd255, 8'd255, 32'hFF000000);
        send_pixel(8'd255, 8'd0, 32'h01FFFFFF);
        send_pixel(8'd0, 8'd255, 32'hFE808080);
        send_pixel(8'd255, 8'd255, 32'hFFFFFFFF);
        send_pixel(8'd1, 8'd0, 32'h80FFFFFF);

        // Zero opacity leaves the colors alone; opacity above one saturates.
        drain_pipeline();
        set_reg(sab_pkg::REG_GALPHA, 0);
        send_pixel(8'd0, 8'd0, 32'hFF00FF00);
        drain_pipeline();
        set_reg(sab_pkg::REG_GALPHA, 511);
        send_pixel(8'd0, 8'd0, 32'hFF0000FF);
        send_pixel(8'd2, 8'd2, 32'hC0A0B0C0);

        // Origin at minus one: column or row zero falls off the screen.
        drain_pipeline();
        set_layout(-1, -1, 0, 0, 256);
        send_pixel(8'd0, 8'd0, 32'hFF112233);
        send_pixel(8'd1, 8'd1, 32'h40445566);
        send_pixel(8'd0, 8'd5, 32'hFF778899);

        // Extreme registers that cancel, then ones that push far off screen.
        drain_pipeline();
        set_layout(32767, -32768, 32767, -32768, 128);
        send_pixel(8'd10, 8'd10, 32'h9ACAFE01);
        drain_pipeline();
        set_reg(sab_pkg::REG_ANCHOR_X, -32768);
        send_pixel(8'd0, 8'd0, 32'hFFFFFFFF);
        drain_pipeline();
        set_layout(-32768, 32767, 32767, -32768, 256);
        send_pixel(8'd255, 8'd255, 32'hFFFFFFFF);

        // A write past the last register must change nothing.
        drain_pipeline();
        set_layout(0, 0, 0, 0, 200);
        set_reg(UNUSED_REG, 32'h0000FFFF);
        send_pixel(8'd3, 8'd3, 32'hA0102030);
        send_pixel(8'd3, 8'd3, 32'h60F0E0D0);

        // Random phases, each with its own layout and idling pattern.
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_pipeline();
            random_layout();
            case (ph % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 51;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 51;
                end
                default:
                begin
                    idle_pct = 23;
                    stall_pct = 23;
                end
            endcase
            base_c = 8'($urandom_range(0, 252));
            base_r = 8'($urandom_range(0, 252));
            for (n = 0; n < PHASE_PIXELS; n++)
            begin
                if (ph == 2 && n == PHASE_PIXELS / 2)
                    drain_pipeline();
                if ($urandom_range(0, 1))
                begin
                    c = base_c + 8'($urandom_range(0, 3));
                    r = base_r + 8'($urandom_range(0, 3));
                end
                else
                begin
                    c = 8'($urandom_range(0, 255));
                    r = 8'($urandom_range(0, 255));
                end
                send_pixel(c, r, rand_argb());
            end
        end

        // Let every result come back, then allow a few more cycles.
        in_valid = 1'b0;
        stall_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (errors == 0)
            $display("sprite_alpha_blit test passed");
        else
            $display("sprite_alpha_blit test failed");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
design/sab_pkg.sv
design/sab_cfg.sv
design/sab_fb_ram.sv
design/sab_blend.sv
design/sprite_alpha_blit.sv
tb/sab_blend_checker.sv
tb/tb_sprite_alpha_blit.sv
